// ===== rtl/tptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tptc_pkg: shared types and constants for the tunnel peer timer control
// Widths, event codes, timer indexes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tptc_pkg;

  // Countdown and jitter widths
  localparam int COUNT_WIDTH  = 24;
  localparam int JITTER_WIDTH = 10;

  // Configuration register widths
  localparam int CFG_W     = 24;
  localparam int ATT_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Width that holds keepalive + rekey + jitter and the saturation limit
  localparam int SUM_W = ((CFG_W + 2) > COUNT_WIDTH) ? (CFG_W + 2) : (COUNT_WIDTH + 1);

  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  // Stream payload widths; the event mode travels on tuser
  localparam int MODE_W      = 4;
  localparam int IN_FIELDS_W = 2 + JITTER_WIDTH;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 16;

  // Timer indexes, also the order in which expiries are handled
  localparam int T_RETX  = 0;
  localparam int T_KEEP  = 1;
  localparam int T_NEWHS = 2;
  localparam int T_ZERO  = 3;
  localparam int T_PERS  = 4;
  localparam int NUM_T   = 5;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] REKEY_RST      = CFG_W'(5000);
  localparam logic [CFG_W-1:0] KEEPALIVE_RST  = CFG_W'(10000);
  localparam logic [CFG_W-1:0] ZERO_KEY_RST   = CFG_W'(540000);
  localparam logic [ATT_W-1:0] MAX_ATT_RST    = ATT_W'(16);
  localparam logic [CFG_W-1:0] PERSISTENT_RST = CFG_W'(0);

  localparam logic [ATT_W-1:0] ATT_SAT = {ATT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REKEY      = 3'd0,
    REG_KEEPALIVE  = 3'd1,
    REG_ZERO_KEY   = 3'd2,
    REG_MAX_ATT    = 3'd3,
    REG_PERSISTENT = 3'd4
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    EV_TICK       = 4'd0,
    EV_DATA_SENT  = 4'd1,
    EV_DATA_RECV  = 4'd2,
    EV_AUTH_SENT  = 4'd3,
    EV_AUTH_RECV  = 4'd4,
    EV_HS_INIT    = 4'd5,
    EV_HS_DONE    = 4'd6,
    EV_SESSION    = 4'd7,
    EV_TRAVERSAL  = 4'd8
  } mode_e;

  // One countdown timer
  typedef struct packed {
    logic                   active;
    logic [COUNT_WIDTH-1:0] count;
  } tmr_t;

  // Tick result of one countdown
  typedef struct packed {
    logic expired;
    tmr_t nxt;
  } tmr_step_t;

  // Saturate an arming delay to the countdown range
  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = (v > COUNT_MAX) ? COUNT_MAX : v;
    return r[COUNT_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/tptc_countdown.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tptc_countdown: one countdown timer step
// On a tick, an active timer at one or less expires and clears; any other
// active timer decrements. Without a tick the timer holds.
// ----------------------------------------------------------------------------
module tptc_countdown (
  input  logic               tick_i,
  input  tptc_pkg::tmr_t     cur_i,
  output tptc_pkg::tmr_step_t step_o
);

  logic at_end;

  assign at_end = (cur_i.count <= tptc_pkg::COUNT_WIDTH'(1));

  // Count down or expire
  always_comb begin
    step_o.expired = 1'b0;
    step_o.nxt     = cur_i;
    if (tick_i && cur_i.active) begin
      if (at_end) begin
        step_o.expired    = 1'b1;
        step_o.nxt.active = 1'b0;
        step_o.nxt.count  = '0;
      end else begin
        step_o.nxt.count = cur_i.count - tptc_pkg::COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// ===== rtl/tunnel_peer_timer_control_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tunnel_peer_timer_control_core: per-peer tunnel timer controller
// A result passes the input register, which loads when the event is accepted, and
// then the result register, which loads when the result stage is free to take it.
// Throughput: one event per cycle while the result stream is not stalled; the five
// countdowns and the flag logic all update together when the event advances.
// Reset clears all timers, the attempt count and the keepalive flag, and
// loads the configuration registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module tunnel_peer_timer_control_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Event stream; tuser: mode[3:0]
  // tdata: jitter, link_running, peer_dead, zero pad
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [tptc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [tptc_pkg::MODE_W-1:0]          s_axis_tuser,
  // Result stream; tdata: send_initiation, initiation_retry, send_keepalive,
  // clear_endpoint_src, purge_staged, zero_keys, attempt_count[7:0], zero pad
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [tptc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tptc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tptc_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int JW = tptc_pkg::JITTER_WIDTH;
  localparam int SW = tptc_pkg::SUM_W;
  localparam int CW = tptc_pkg::COUNT_WIDTH;

  // Configuration registers
  logic [tptc_pkg::CFG_W-1:0] rekey_q, keepalive_q, zero_key_q, persistent_q;
  logic [tptc_pkg::ATT_W-1:0] max_att_q;

  // Input stage
  logic                             in_valid_q;
  logic [tptc_pkg::MODE_W-1:0]      in_user_q;
  logic [tptc_pkg::IN_FIELDS_W-1:0] in_data_q;

  // Result stage
  logic                           out_valid_q, out_valid_d;
  logic [tptc_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Peer state
  tptc_pkg::tmr_t             tmr_q [tptc_pkg::NUM_T];
  tptc_pkg::tmr_t             tmr_d [tptc_pkg::NUM_T];
  tptc_pkg::tmr_step_t        step  [tptc_pkg::NUM_T];
  logic [tptc_pkg::ATT_W-1:0] att_q, att_d;
  logic                       nak_q, nak_d;

  logic advance;

  // Decoded event fields
  tptc_pkg::mode_e mode;
  logic [JW-1:0]   jitter;
  logic            link, dead, ok, tick;

  // Arming delays
  logic [CW-1:0] d_retx, d_newhs, d_keep, d_zero, d_pers;

  // Action flags
  logic s_init, retry, s_keep, clr, purge, zk, keep_exp;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign mode   = tptc_pkg::mode_e'(in_user_q);
  assign jitter = in_data_q[0 +: JW];
  assign link   = in_data_q[JW];
  assign dead   = in_data_q[JW + 1];
  assign ok     = link && !dead;
  assign tick   = (mode == tptc_pkg::EV_TICK);

  assign d_retx  = tptc_pkg::sat_count(SW'(rekey_q) + SW'(jitter));
  assign d_newhs = tptc_pkg::sat_count(SW'(keepalive_q) + SW'(rekey_q) + SW'(jitter));
  assign d_keep  = tptc_pkg::sat_count(SW'(keepalive_q));
  assign d_zero  = tptc_pkg::sat_count(SW'(zero_key_q));
  assign d_pers  = tptc_pkg::sat_count(SW'(persistent_q));

  // Step every countdown in parallel
  for (genvar g = 0; g < tptc_pkg::NUM_T; g++) begin : g_cd
    tptc_countdown u_cd (
      .tick_i (tick),
      .cur_i  (tmr_q[g]),
      .step_o (step[g])
    );
  end

  // Event handling
  always_comb begin
    for (int i = 0; i < tptc_pkg::NUM_T; i++) begin
      tmr_d[i] = tmr_q[i];
    end
    att_d    = att_q;
    nak_d    = nak_q;
    s_init   = 1'b0;
    retry    = 1'b0;
    s_keep   = 1'b0;
    clr      = 1'b0;
    purge    = 1'b0;
    zk       = 1'b0;
    keep_exp = 1'b0;

    case (mode)
      tptc_pkg::EV_TICK: begin
        for (int i = 0; i < tptc_pkg::NUM_T; i++) begin
          tmr_d[i] = step[i].nxt;
        end
        keep_exp = step[tptc_pkg::T_KEEP].expired;
        // Retransmit: retry or give up
        if (step[tptc_pkg::T_RETX].expired) begin
          if (att_q > max_att_q) begin
            tmr_d[tptc_pkg::T_KEEP] = '0;
            keep_exp = 1'b0;
            purge    = 1'b1;
            if (!tmr_q[tptc_pkg::T_ZERO].active && ok) begin
              tmr_d[tptc_pkg::T_ZERO] = {1'b1, d_zero};
            end
          end else begin
            if (att_q != tptc_pkg::ATT_SAT) begin
              att_d = att_q + tptc_pkg::ATT_W'(1);
            end
            clr    = 1'b1;
            s_init = 1'b1;
            retry  = 1'b1;
          end
        end
        // Passive keepalive
        if (keep_exp) begin
          s_keep = 1'b1;
          if (nak_q) begin
            nak_d = 1'b0;
            if (ok) begin
              tmr_d[tptc_pkg::T_KEEP] = {1'b1, d_keep};
            end
          end
        end
        // New handshake overrides the retry marking
        if (step[tptc_pkg::T_NEWHS].expired) begin
          clr    = 1'b1;
          s_init = 1'b1;
          retry  = 1'b0;
        end
        if (step[tptc_pkg::T_ZERO].expired && !dead) begin
          zk = 1'b1;
        end
        if (step[tptc_pkg::T_PERS].expired && (persistent_q != '0)) begin
          s_keep = 1'b1;
        end
      end
      tptc_pkg::EV_DATA_SENT: begin
        if (!tmr_q[tptc_pkg::T_NEWHS].active && ok) begin
          tmr_d[tptc_pkg::T_NEWHS] = {1'b1, d_newhs};
        end
      end
      tptc_pkg::EV_DATA_RECV: begin
        if (link) begin
          if (!tmr_q[tptc_pkg::T_KEEP].active) begin
            if (ok) begin
              tmr_d[tptc_pkg::T_KEEP] = {1'b1, d_keep};
            end
          end else begin
            nak_d = 1'b1;
          end
        end
      end
      tptc_pkg::EV_AUTH_SENT: begin
        tmr_d[tptc_pkg::T_KEEP] = '0;
      end
      tptc_pkg::EV_AUTH_RECV: begin
        tmr_d[tptc_pkg::T_NEWHS] = '0;
      end
      tptc_pkg::EV_HS_INIT: begin
        if (ok) begin
          tmr_d[tptc_pkg::T_RETX] = {1'b1, d_retx};
        end
      end
      tptc_pkg::EV_HS_DONE: begin
        tmr_d[tptc_pkg::T_RETX] = '0;
        att_d = '0;
      end
      tptc_pkg::EV_SESSION: begin
        if (ok) begin
          tmr_d[tptc_pkg::T_ZERO] = {1'b1, d_zero};
        end
      end
      tptc_pkg::EV_TRAVERSAL: begin
        if (ok && (persistent_q != '0)) begin
          tmr_d[tptc_pkg::T_PERS] = {1'b1, d_pers};
        end
      end
      default: begin
      end
    endcase
  end

  // Pack result and advance the result stage
  always_comb begin
    out_data_d  = {2'b00, att_d, zk, purge, clr, s_keep, retry, s_init};
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold input and result stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_user_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata[tptc_pkg::IN_FIELDS_W-1:0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // Update peer state once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tptc_pkg::NUM_T; i++) begin
        tmr_q[i] <= '0;
      end
      att_q <= '0;
      nak_q <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < tptc_pkg::NUM_T; i++) begin
        tmr_q[i] <= tmr_d[i];
      end
      att_q <= att_d;
      nak_q <= nak_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rekey_q      <= tptc_pkg::REKEY_RST;
      keepalive_q  <= tptc_pkg::KEEPALIVE_RST;
      zero_key_q   <= tptc_pkg::ZERO_KEY_RST;
      max_att_q    <= tptc_pkg::MAX_ATT_RST;
      persistent_q <= tptc_pkg::PERSISTENT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tptc_pkg::reg_idx_e'(cfg_index_i))
        tptc_pkg::REG_REKEY:      rekey_q      <= cfg_data_i;
        tptc_pkg::REG_KEEPALIVE:  keepalive_q  <= cfg_data_i;
        tptc_pkg::REG_ZERO_KEY:   zero_key_q   <= cfg_data_i;
        tptc_pkg::REG_MAX_ATT:    max_att_q    <= cfg_data_i[tptc_pkg::ATT_W-1:0];
        tptc_pkg::REG_PERSISTENT: persistent_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_retry_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("initiation_retry without send_initiation");

  a_purge_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[1])
    else $error("give-up and retry in one result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(att_q) && $stable(nak_q)))
    else $error("peer state changed without a transaction");

  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=>
      (in_valid_q && $stable(in_user_q) && $stable(in_data_q)))
    else $error("stalled event lost from input stage");

endmodule

// ===== tb/tunnel_peer_timer_control_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tunnel_peer_timer_control_core_test: self-checking bench for the peer timers
// Drives timer events on the input stream and predicts every action result
// with an in-bench copy of the five countdowns, the attempt count and the
// keepalive flag. Results are compared field by field in arrival order.
// Covers directed corner cases, then random phases under several settings,
// with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tunnel_peer_timer_control_core_test;
  import tptc_pkg::*;

  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_PHASE      = 2;
  localparam int MAX_LOG_LINES   = 50;

  // Index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One event transaction; mode goes out on tuser, the rest on tdata
  typedef struct packed {
    logic                    dead;
    logic                    link;
    logic [JITTER_WIDTH-1:0] jitter;
    logic [3:0]              mode;
  } peer_event_t;

  // One action result, highest field first
  typedef struct packed {
    logic [ATT_W-1:0] attempts;
    logic             zero_keys;
    logic             purge;
    logic             clr_src;
    logic             keepalive;
    logic             retry;
    logic             initiation;
  } timer_action_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  tunnel_peer_timer_control_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted peer state and its configuration copy
  tmr_t             peer_tmr [NUM_T];
  logic [ATT_W-1:0] att_cnt;
  logic             keep_again;
  logic [CFG_W-1:0] rekey_cfg;
  logic [CFG_W-1:0] keepalive_cfg;
  logic [CFG_W-1:0] zero_key_cfg;
  logic [ATT_W-1:0] max_att_cfg;
  logic [CFG_W-1:0] persistent_cfg;

  peer_event_t   event_q [$];
  timer_action_t action_q [$];
  peer_event_t   offered_ev;
  int            src_gap;
  int            snk_gap;
  int            hold_left;
  bit            hold_done;
  bit            hold_req  = 1'b0;
  bit            idle_en   = 1'b0;
  int            err_cnt   = 0;

  // Restart a timer, saturating the delay to the countdown range
  function automatic void arm_timer(int idx, logic [SUM_W-1:0] delay, logic allowed);
    if (allowed) begin
      peer_tmr[idx].active = 1'b1;
      peer_tmr[idx].count  = (delay > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                 : delay[COUNT_WIDTH-1:0];
    end
  endfunction

  // Apply one event to the predicted state and return the expected actions
  function automatic timer_action_t advance_peer_timers(peer_event_t ev);
    timer_action_t    act;
    logic [NUM_T-1:0] fired;
    logic             ok;
    act   = '0;
    fired = '0;
    ok    = ev.link && !ev.dead;
    case (ev.mode)
      EV_TICK: begin
        // Count down; expired timers stay visible until handled below
        for (int i = 0; i < NUM_T; i++) begin
          if (peer_tmr[i].active) begin
            if (peer_tmr[i].count <= 1) fired[i] = 1'b1;
            else peer_tmr[i].count = peer_tmr[i].count - 1'b1;
          end
        end
        // Retransmit: retry, or give up and drop this tick's keepalive
        if (fired[T_RETX]) begin
          peer_tmr[T_RETX] = '0;
          if (att_cnt > max_att_cfg) begin
            peer_tmr[T_KEEP] = '0;
            fired[T_KEEP]    = 1'b0;
            act.purge        = 1'b1;
            if (!peer_tmr[T_ZERO].active) arm_timer(T_ZERO, SUM_W'(zero_key_cfg), ok);
          end else begin
            if (att_cnt != ATT_SAT) att_cnt = att_cnt + 1'b1;
            act.clr_src    = 1'b1;
            act.initiation = 1'b1;
            act.retry      = 1'b1;
          end
        end
        if (fired[T_KEEP]) begin
          peer_tmr[T_KEEP] = '0;
          act.keepalive    = 1'b1;
          if (keep_again) begin
            keep_again = 1'b0;
            arm_timer(T_KEEP, SUM_W'(keepalive_cfg), ok);
          end
        end
        // New handshake comes last, so it wins over a retry in the same tick
        if (fired[T_NEWHS]) begin
          peer_tmr[T_NEWHS] = '0;
          act.clr_src       = 1'b1;
          act.initiation    = 1'b1;
          act.retry         = 1'b0;
        end
        if (fired[T_ZERO]) begin
          peer_tmr[T_ZERO] = '0;
          if (!ev.dead) act.zero_keys = 1'b1;
        end
        if (fired[T_PERS]) begin
          peer_tmr[T_PERS] = '0;
          if (persistent_cfg != '0) act.keepalive = 1'b1;
        end
      end
      EV_DATA_SENT: begin
        if (!peer_tmr[T_NEWHS].active)
          arm_timer(T_NEWHS, SUM_W'(keepalive_cfg) + SUM_W'(rekey_cfg) + SUM_W'(ev.jitter), ok);
      end
      EV_DATA_RECV: begin
        if (ev.link) begin
          if (!peer_tmr[T_KEEP].active) arm_timer(T_KEEP, SUM_W'(keepalive_cfg), ok);
          else keep_again = 1'b1;
        end
      end
      EV_AUTH_SENT: peer_tmr[T_KEEP] = '0;
      EV_AUTH_RECV: peer_tmr[T_NEWHS] = '0;
      EV_HS_INIT:   arm_timer(T_RETX, SUM_W'(rekey_cfg) + SUM_W'(ev.jitter), ok);
      EV_HS_DONE: begin
        peer_tmr[T_RETX] = '0;
        att_cnt          = '0;
      end
      EV_SESSION:   arm_timer(T_ZERO, SUM_W'(zero_key_cfg), ok);
      EV_TRAVERSAL: begin
        if (persistent_cfg != '0) arm_timer(T_PERS, SUM_W'(persistent_cfg), ok);
      end
      default: ;
    endcase
    act.attempts = att_cnt;
    return act;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random event, weighted toward ticks and handshake traffic
  function automatic peer_event_t random_event();
    peer_event_t ev;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      ev.mode = EV_TICK;
    else if (pick < 52) ev.mode = EV_DATA_SENT;
    else if (pick < 62) ev.mode = EV_DATA_RECV;
    else if (pick < 66) ev.mode = EV_AUTH_SENT;
    else if (pick < 70) ev.mode = EV_AUTH_RECV;
    else if (pick < 81) ev.mode = EV_HS_INIT;
    else if (pick < 85) ev.mode = EV_HS_DONE;
    else if (pick < 90) ev.mode = EV_SESSION;
    else if (pick < 96) ev.mode = EV_TRAVERSAL;
    else                ev.mode = 4'($urandom_range(int'(EV_TRAVERSAL) + 1, 15));
    ev.jitter = ($urandom_range(0, 6) == 0) ? JITTER_WIDTH'($urandom)
                                            : JITTER_WIDTH'($urandom_range(0, 3));
    ev.link   = ($urandom_range(0, 9) != 0);
    ev.dead   = ($urandom_range(0, 11) == 0);
    return ev;
  endfunction

  task automatic add_event(input logic [3:0] mode, input logic [JITTER_WIDTH-1:0] jitter,
                           input logic link, input logic dead);
    peer_event_t ev;
    ev.mode   = mode;
    ev.jitter = jitter;
    ev.link   = link;
    ev.dead   = dead;
    event_q.push_back(ev);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    // Keep the log short when everything goes wrong
    if (err_cnt <= MAX_LOG_LINES)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Write one register and update the predicted configuration on handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_REKEY:      rekey_cfg      = val;
      REG_KEEPALIVE:  keepalive_cfg  = val;
      REG_ZERO_KEY:   zero_key_cfg   = val;
      REG_MAX_ATT:    max_att_cfg    = val[ATT_W-1:0];
      REG_PERSISTENT: persistent_cfg = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CFG_W-1:0] rekey, input logic [CFG_W-1:0] keep,
                             input logic [CFG_W-1:0] zero, input logic [ATT_W-1:0] max_att,
                             input logic [CFG_W-1:0] pers);
    write_reg(REG_REKEY, rekey);
    write_reg(REG_KEEPALIVE, keep);
    write_reg(REG_ZERO_KEY, zero);
    write_reg(REG_MAX_ATT, CFG_W'(max_att));
    write_reg(REG_PERSISTENT, pers);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every event to be taken and every result to arrive
  task automatic wait_idle();
    @(negedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || action_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Event driver: predict on each accepted transaction, then offer the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) action_q.push_back(advance_peer_timers(offered_ev));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          offered_ev = event_q.pop_front();
          s_axis_tuser  <= offered_ev.mode;
          s_axis_tdata  <= IN_DATA_W'({offered_ev.dead, offered_ev.link, offered_ev.jitter});
          s_axis_tvalid <= 1'b1;
          src_gap = idle_en ? draw_gap() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, counted here, requested once by the stimulus
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result receiver with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_en) snk_gap = draw_gap();
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    timer_action_t got;
    timer_action_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(timer_action_t)-1:0];
      if (action_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = action_q.pop_front();
        check_field("send_initiation", got.initiation, want.initiation);
        check_field("initiation_retry", got.retry, want.retry);
        check_field("send_keepalive", got.keepalive, want.keepalive);
        check_field("clear_endpoint_src", got.clr_src, want.clr_src);
        check_field("purge_staged", got.purge, want.purge);
        check_field("zero_keys", got.zero_keys, want.zero_keys);
        check_field("attempt_count", got.attempts, want.attempts);
      end
    end
  end

  initial begin
    // Reset values of the predicted state
    for (int i = 0; i < NUM_T; i++) peer_tmr[i] = '0;
    att_cnt        = '0;
    keep_again     = 1'b0;
    rekey_cfg      = REKEY_RST;
    keepalive_cfg  = KEEPALIVE_RST;
    zero_key_cfg   = ZERO_KEY_RST;
    max_att_cfg    = MAX_ATT_RST;
    persistent_cfg = PERSISTENT_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Arm under the reset settings; restarted below with short delays
    add_event(EV_HS_INIT, '1, 1'b1, 1'b0);
    wait_idle();

    load_config(24'd2, 24'd3, 24'd4, 8'd0, 24'd2);
    add_event(EV_DATA_RECV, '0, 1'b0, 1'b0);   // link down: nothing happens
    add_event(EV_DATA_SENT, '0, 1'b1, 1'b0);   // new handshake in 5
    add_event(EV_HS_INIT, 10'd3, 1'b1, 1'b0);  // retransmit in 5 as well
    add_event(EV_DATA_RECV, '0, 1'b1, 1'b0);   // keepalive in 3
    add_event(EV_DATA_RECV, '0, 1'b1, 1'b0);   // ask for another keepalive
    add_event(EV_TRAVERSAL, '0, 1'b1, 1'b0);
    add_event(EV_SESSION, '0, 1'b1, 1'b0);
    // Persistent, keepalive with rearm, zero key, then both initiations at once
    repeat (5) add_event(EV_TICK, '0, 1'b1, 1'b0);
    add_event(EV_HS_INIT, '1, 1'b1, 1'b1);     // dead peer: not armed
    add_event(EV_AUTH_SENT, '0, 1'b1, 1'b0);
    add_event(EV_DATA_RECV, '0, 1'b1, 1'b0);
    add_event(EV_HS_INIT, 10'd1, 1'b1, 1'b0);
    // Give up in the same tick as the keepalive expiry
    repeat (3) add_event(EV_TICK, '0, 1'b1, 1'b0);
    // Zero key expires on a dead peer
    repeat (4) add_event(EV_TICK, '0, 1'b1, 1'b1);
    add_event(EV_AUTH_RECV, '0, 1'b1, 1'b0);
    add_event(EV_HS_DONE, '0, 1'b1, 1'b0);
    add_event(4'hF, '1, 1'b1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_config('1, '1, '1, ATT_SAT - 1'b1, '1);
        1:       load_config('0, '0, '0, '0, '0);
        5:       load_config(24'd3, 24'd4, 24'd6, ATT_SAT, 24'd3);
        default: load_config(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)),
                             CFG_W'($urandom_range(0, 30)),
                             ($urandom_range(0, 9) == 0) ? ATT_SAT
                                                         : ATT_W'($urandom_range(0, 4)),
                             CFG_W'($urandom_range(0, 8)));
      endcase
      idle_en  <= (ph != HOLD_PHASE) && (ph % 3 != 1);
      hold_req <= (ph == HOLD_PHASE);
      repeat (ITEMS_PER_PHASE) event_q.push_back(random_event());
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
